>>> rtl/cdms_pkg.sv
// Shared constants and types for the closest divisor multiple search core.
package cdms_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_V,
    ST_UP_S,
    ST_LO_V,
    ST_LO_S,
    ST_FINISH
  } state_t;

  // request to the shared remainder unit
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } rem_req_t;

endpackage

>>> rtl/cdms_rem.sv
// Shared restoring remainder unit: one quotient bit per cycle.
module cdms_rem
  import cdms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output logic     done,
  output word_t    rem
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            quo_r, quo_nxt;
  word_t            rem_r, rem_nxt;
  word_t            div_r, div_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem_r, quo_r[WIDTH-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
      end else begin
        rem_nxt = trial[WIDTH-1:0];
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> req.divisor != '0)
    else $error("remainder unit started with zero divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("remainder done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("remainder unit restarted while busy");

endmodule

>>> rtl/closest_divisor_multiple_search_core.sv
// Top level: sequencer that scans divisor candidates through the shared remainder unit.
// Trivial request (target >= value or step >= value): goes straight to the finish state.
// Otherwise each candidate takes one remainder run for value % cand, plus one more for
// cand % step when it divides and step > 1; the scan runs up from target, then down to 2.
// Busy holds while the scan runs.
// Synchronous active-low reset returns the sequencer to idle; the result cannot be stalled.
module closest_divisor_multiple_search_core
  import cdms_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  word_t in_target,
  input  word_t in_value,
  input  word_t in_step,
  output logic  out_valid,
  output word_t out_chosen_divisor
);

  state_t   state_r, state_nxt;
  word_t    tgt_r, tgt_nxt;
  word_t    value_r, value_nxt;
  word_t    step_r, step_nxt;
  word_t    cand_r, cand_nxt;
  word_t    up_r, up_nxt;
  word_t    lo_r, lo_nxt;
  logic     have_lo_r, have_lo_nxt;
  logic     out_valid_r, out_valid_nxt;
  word_t    out_div_r, out_div_nxt;

  rem_req_t rem_req;
  logic     rem_done;
  word_t    rem_val;

  word_t    tgt_in;
  logic     step_free;
  logic     up_adv, lo_launch, lo_adv;

  cdms_rem u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (rem_req),
    .done (rem_done),
    .rem  (rem_val)
  );

  assign tgt_in    = (in_target == '0) ? word_t'(1) : in_target;
  assign step_free = (step_r[WIDTH-1:1] == '0);

  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    value_nxt     = value_r;
    step_nxt      = step_r;
    cand_nxt      = cand_r;
    up_nxt        = up_r;
    lo_nxt        = lo_r;
    have_lo_nxt   = have_lo_r;
    out_valid_nxt = 1'b0;
    out_div_nxt   = out_div_r;
    rem_req       = '0;
    up_adv        = 1'b0;
    lo_launch     = 1'b0;
    lo_adv        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          tgt_nxt     = tgt_in;
          value_nxt   = in_value;
          step_nxt    = in_step;
          up_nxt      = in_value;
          have_lo_nxt = 1'b0;
          if (tgt_in >= in_value || in_step >= in_value) begin
            state_nxt = ST_FINISH;
          end else begin
            cand_nxt         = tgt_in;
            rem_req.start    = 1'b1;
            rem_req.dividend = in_value;
            rem_req.divisor  = tgt_in;
            state_nxt        = ST_UP_V;
          end
        end
      end
      ST_UP_V: begin
        if (rem_done) begin
          if (rem_val != '0) begin
            up_adv = 1'b1;
          end else if (step_free) begin
            up_nxt    = cand_r;
            lo_launch = 1'b1;
          end else begin
            rem_req.start    = 1'b1;
            rem_req.dividend = cand_r;
            rem_req.divisor  = step_r;
            state_nxt        = ST_UP_S;
          end
        end
      end
      ST_UP_S: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            up_nxt    = cand_r;
            lo_launch = 1'b1;
          end else begin
            up_adv = 1'b1;
          end
        end
      end
      ST_LO_V: begin
        if (rem_done) begin
          if (rem_val != '0) begin
            lo_adv = 1'b1;
          end else if (step_free) begin
            lo_nxt      = cand_r;
            have_lo_nxt = 1'b1;
            state_nxt   = ST_FINISH;
          end else begin
            rem_req.start    = 1'b1;
            rem_req.dividend = cand_r;
            rem_req.divisor  = step_r;
            state_nxt        = ST_LO_S;
          end
        end
      end
      ST_LO_S: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            lo_nxt      = cand_r;
            have_lo_nxt = 1'b1;
            state_nxt   = ST_FINISH;
          end else begin
            lo_adv = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        // no upper hit leaves up_r at the value itself
        if (!have_lo_r) begin
          out_div_nxt = up_r;
        end else if (up_r == value_r) begin
          out_div_nxt = lo_r;
        end else if ((tgt_r - lo_r) < (up_r - tgt_r)) begin
          out_div_nxt = lo_r;
        end else begin
          out_div_nxt = up_r;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (up_adv) begin
      if (cand_r + word_t'(1) == value_r) begin
        lo_launch = 1'b1;
      end else begin
        cand_nxt         = cand_r + word_t'(1);
        rem_req.start    = 1'b1;
        rem_req.dividend = value_r;
        rem_req.divisor  = cand_r + word_t'(1);
        state_nxt        = ST_UP_V;
      end
    end

    if (lo_launch) begin
      if (tgt_r < word_t'(3)) begin
        state_nxt = ST_FINISH;
      end else begin
        cand_nxt         = tgt_r - word_t'(1);
        rem_req.start    = 1'b1;
        rem_req.dividend = value_r;
        rem_req.divisor  = tgt_r - word_t'(1);
        state_nxt        = ST_LO_V;
      end
    end

    if (lo_adv) begin
      if (cand_r < word_t'(3)) begin
        state_nxt = ST_FINISH;
      end else begin
        cand_nxt         = cand_r - word_t'(1);
        rem_req.start    = 1'b1;
        rem_req.dividend = value_r;
        rem_req.divisor  = cand_r - word_t'(1);
        state_nxt        = ST_LO_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r     <= tgt_nxt;
    value_r   <= value_nxt;
    step_r    <= step_nxt;
    cand_r    <= cand_nxt;
    up_r      <= up_nxt;
    lo_r      <= lo_nxt;
    have_lo_r <= have_lo_nxt;
    out_div_r <= out_div_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_chosen_divisor = out_div_r;

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start the sequencer");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == ST_UP_V || state_r == ST_UP_S ||
                  state_r == ST_LO_V || state_r == ST_LO_S))
    else $error("remainder result arrived outside a scan state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FINISH))
    else $error("result strobe without finish state");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

endmodule
